>>> rtl/size_limited_disjoint_set_union_defines.svh
// ----------------------------------------------------------------------------
// size_limited_disjoint_set_union_defines
// assertion macros shared by the disjoint-set engine
// ----------------------------------------------------------------------------
`ifndef SIZE_LIMITED_DISJOINT_SET_UNION_DEFINES_SVH
`define SIZE_LIMITED_DISJOINT_SET_UNION_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SLDSU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the cycle after
`define SLDSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sldsu_pkg.sv
// ----------------------------------------------------------------------------
// sldsu_pkg
// shared types and codes of the disjoint-set engine
// ----------------------------------------------------------------------------
package sldsu_pkg;

    localparam logic [1:0] FUNC_QUERY   = 2'd0;
    localparam logic [1:0] FUNC_BOUNDED = 2'd1;
    localparam logic [1:0] FUNC_SMALL   = 2'd2;
    localparam logic [1:0] FUNC_PLAIN   = 2'd3;

    localparam logic [1:0] CFG_MAX_SET_SIZE = 2'd0;
    localparam logic [1:0] CFG_TARGET_SETS  = 2'd1;
    localparam logic [1:0] CFG_MIN_SET_SIZE = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [9:0] node_a;
        logic [9:0] node_b;
    } in_t;

    typedef struct packed {
        logic [9:0]  root_a;
        logic [9:0]  root_b;
        logic        same_set;
        logic        merged;
        logic [10:0] set_size;
        logic [10:0] set_count;
    } out_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_REDUCE,
        OP_START,
        OP_READ_CUR,
        OP_STEP,
        OP_SET_ROOT,
        OP_WRITE_COMP,
        OP_SAVE_ROOT,
        OP_READ_RA,
        OP_LATCH_A,
        OP_READ_RB,
        OP_LATCH_B,
        OP_DECIDE,
        OP_MERGE_LOSER,
        OP_MERGE_WINNER,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   sel_b;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic reduced;
        logic at_root;
        logic cur_is_root;
        logic do_merge;
    } dp_status_t;

endpackage

>>> rtl/sldsu_dp.sv
// ----------------------------------------------------------------------------
// sldsu_dp
// node store, find/merge datapath and configuration registers
// ----------------------------------------------------------------------------
module sldsu_dp #(
    parameter int NODES = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sldsu_pkg::dp_cmd_t   cmd,
    output sldsu_pkg::dp_status_t status,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_addr,
    input  logic [10:0]          cfg_data,
    input  sldsu_pkg::in_t       in_item,
    output sldsu_pkg::out_t      out_item
);
    import sldsu_pkg::*;

    localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int SW = $clog2(NODES + 1);
    localparam int CW = (SW + 1 > 12) ? SW + 1 : 12;
    localparam logic [16:0]   NODES_V  = 17'(NODES);
    localparam logic [9:0]    NODES_LO = 10'(NODES);
    localparam logic [IW-1:0] LAST_IDX = IW'(NODES - 1);
    localparam logic [CW-1:0] SAT_MAX  = CW'(2047);

    logic [IW-1:0] par_mem  [NODES];
    logic [3:0]    rank_mem [NODES];
    logic [SW-1:0] size_mem [NODES];

    logic [IW-1:0] par_rd_reg;
    logic [3:0]    rank_rd_reg;
    logic [SW-1:0] size_rd_reg;

    logic [1:0]    func_reg;
    logic [9:0]    a_reg, b_reg;
    logic [IW-1:0] cur_reg, root_reg, ra_reg, rb_reg, clr_reg;
    logic [3:0]    rank_a_reg, rank_b_reg;
    logic [SW-1:0] size_a_reg, size_b_reg, count_reg;
    logic [10:0]   max_reg, target_reg, min_reg;
    logic          same_reg, merged_reg;
    out_t          out_reg;

    logic [IW-1:0] a_idx, b_idx, start_idx;
    logic          a_big, b_big;
    logic [CW-1:0] sum;
    logic          bounded_ok, small_ok, func_ok, do_merge;
    logic          a_wins;
    logic [IW-1:0] winner, loser;
    logic [3:0]    loser_rank, winner_rank;
    logic [SW-1:0] loser_size;
    logic          mem_we, mem_re;
    logic [IW-1:0] waddr, raddr, wpar;
    logic [3:0]    wrank;
    logic [SW-1:0] wsize;
    logic [10:0]   size_out, count_out;

    assign a_idx     = IW'(a_reg);
    assign b_idx     = IW'(b_reg);
    assign start_idx = cmd.sel_b ? b_idx : a_idx;
    assign a_big     = {7'b0, a_reg} >= NODES_V;
    assign b_big     = {7'b0, b_reg} >= NODES_V;

    assign sum        = CW'(size_a_reg) + CW'(size_b_reg);
    assign bounded_ok = (sum <= CW'(max_reg)) && (CW'(count_reg) > CW'(target_reg));
    assign small_ok   = (CW'(size_a_reg) < CW'(min_reg)) || (CW'(size_b_reg) < CW'(min_reg));

    always_comb
    begin
        case (func_reg)
            FUNC_BOUNDED: func_ok = bounded_ok;
            FUNC_SMALL:   func_ok = small_ok;
            FUNC_PLAIN:   func_ok = 1'b1;
            default:      func_ok = 1'b0;
        endcase
    end

    assign do_merge = (ra_reg != rb_reg) && func_ok;

    // higher rank wins, ties go to root b
    assign a_wins      = rank_a_reg > rank_b_reg;
    assign winner      = a_wins ? ra_reg : rb_reg;
    assign loser       = a_wins ? rb_reg : ra_reg;
    assign loser_rank  = a_wins ? rank_b_reg : rank_a_reg;
    assign loser_size  = a_wins ? size_b_reg : size_a_reg;
    assign winner_rank = (!a_wins && rank_a_reg == rank_b_reg && rank_b_reg != 4'd15)
                         ? rank_b_reg + 4'd1 : (a_wins ? rank_a_reg : rank_b_reg);

    always_comb
    begin
        mem_we = 1'b1;
        waddr  = cur_reg;
        wpar   = root_reg;
        wrank  = rank_rd_reg;
        wsize  = size_rd_reg;
        case (cmd.op)
            OP_CLEAR:
            begin
                waddr = clr_reg;
                wpar  = clr_reg;
                wrank = 4'd0;
                wsize = SW'(1);
            end
            OP_WRITE_COMP:
            begin
                waddr = cur_reg;
            end
            OP_MERGE_LOSER:
            begin
                waddr = loser;
                wpar  = winner;
                wrank = loser_rank;
                wsize = loser_size;
            end
            OP_MERGE_WINNER:
            begin
                waddr = winner;
                wpar  = winner;
                wrank = winner_rank;
                wsize = SW'(sum);
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_comb
    begin
        mem_re = 1'b1;
        case (cmd.op)
            OP_READ_CUR: raddr = cur_reg;
            OP_READ_RA:  raddr = ra_reg;
            OP_READ_RB:  raddr = rb_reg;
            default:
            begin
                mem_re = 1'b0;
                raddr  = cur_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            par_mem[waddr]  <= wpar;
            rank_mem[waddr] <= wrank;
            size_mem[waddr] <= wsize;
        end
        if (mem_re)
        begin
            par_rd_reg  <= par_mem[raddr];
            rank_rd_reg <= rank_mem[raddr];
            size_rd_reg <= size_mem[raddr];
        end
    end

    assign size_out  = (CW'(size_rd_reg) > SAT_MAX) ? 11'd2047 : 11'(size_rd_reg);
    assign count_out = (CW'(count_reg) > SAT_MAX) ? 11'd2047 : 11'(count_reg);

    // control state: clear counter, set count, configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg    <= '0;
            count_reg  <= SW'(NODES);
            max_reg    <= 11'd1024;
            target_reg <= 11'd1;
            min_reg    <= 11'd0;
        end
        else
        begin
            if (cmd.op == OP_CLEAR)
                clr_reg <= clr_reg + IW'(1);
            if (cmd.op == OP_MERGE_WINNER)
                count_reg <= count_reg - SW'(1);
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_MAX_SET_SIZE: max_reg    <= cfg_data;
                    CFG_TARGET_SETS:  target_reg <= cfg_data;
                    CFG_MIN_SET_SIZE: min_reg    <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                func_reg <= in_item.func;
                a_reg    <= in_item.node_a;
                b_reg    <= in_item.node_b;
            end
            OP_REDUCE:
            begin
                if (a_big)
                    a_reg <= a_reg - NODES_LO;
                if (b_big)
                    b_reg <= b_reg - NODES_LO;
            end
            OP_START:      cur_reg <= start_idx;
            OP_STEP:       cur_reg <= par_rd_reg;
            OP_SET_ROOT:
            begin
                root_reg <= cur_reg;
                cur_reg  <= start_idx;
            end
            OP_WRITE_COMP: cur_reg <= par_rd_reg;
            OP_SAVE_ROOT:
            begin
                if (cmd.sel_b)
                    rb_reg <= root_reg;
                else
                    ra_reg <= root_reg;
            end
            OP_LATCH_A:
            begin
                rank_a_reg <= rank_rd_reg;
                size_a_reg <= size_rd_reg;
            end
            OP_LATCH_B:
            begin
                rank_b_reg <= rank_rd_reg;
                size_b_reg <= size_rd_reg;
            end
            OP_DECIDE:
            begin
                same_reg   <= ra_reg == rb_reg;
                merged_reg <= do_merge;
            end
            OP_RESULT:
            begin
                out_reg.root_a    <= 10'(ra_reg);
                out_reg.root_b    <= 10'(rb_reg);
                out_reg.same_set  <= same_reg;
                out_reg.merged    <= merged_reg;
                out_reg.set_size  <= size_out;
                out_reg.set_count <= count_out;
            end
            default: ;
        endcase
    end

    assign status.clear_last  = clr_reg == LAST_IDX;
    assign status.reduced     = !a_big && !b_big;
    assign status.at_root     = par_rd_reg == cur_reg;
    assign status.cur_is_root = cur_reg == root_reg;
    assign status.do_merge    = do_merge;
    assign out_item           = out_reg;

endmodule

>>> rtl/sldsu_ctrl.sv
// ----------------------------------------------------------------------------
// sldsu_ctrl
// sequencer for clear pass, finds, merge and result transfer
// ----------------------------------------------------------------------------
module sldsu_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  sldsu_pkg::dp_status_t status,
    output sldsu_pkg::dp_cmd_t    cmd
);
    import sldsu_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_REDUCE,
        S_F_RD,
        S_F_CHK,
        S_C_TEST,
        S_C_WR,
        S_NEXT,
        S_RD_A,
        S_LT_A,
        S_RD_B,
        S_LT_B,
        S_DECIDE,
        S_MERGE_L,
        S_MERGE_W,
        S_RESTART,
        S_RD_SIZE,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   find_b_reg, find_b_next;
    logic   second_reg, second_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        find_b_next    = find_b_reg;
        second_next    = second_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = OP_NONE;
        cmd.sel_b      = find_b_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (status.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op      = OP_LOAD;
                    find_b_next = 1'b0;
                    second_next = 1'b0;
                    state_next  = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                if (status.reduced)
                begin
                    cmd.op     = OP_START;
                    cmd.sel_b  = 1'b0;
                    state_next = S_F_RD;
                end
                else
                    cmd.op = OP_REDUCE;
            end
            S_F_RD:
            begin
                cmd.op     = OP_READ_CUR;
                state_next = S_F_CHK;
            end
            S_F_CHK:
            begin
                if (status.at_root)
                begin
                    cmd.op     = OP_SET_ROOT;
                    state_next = S_C_TEST;
                end
                else
                begin
                    cmd.op     = OP_STEP;
                    state_next = S_F_RD;
                end
            end
            S_C_TEST:
            begin
                if (status.cur_is_root)
                begin
                    cmd.op     = OP_SAVE_ROOT;
                    state_next = S_NEXT;
                end
                else
                begin
                    cmd.op     = OP_READ_CUR;
                    state_next = S_C_WR;
                end
            end
            S_C_WR:
            begin
                cmd.op     = OP_WRITE_COMP;
                state_next = S_C_TEST;
            end
            S_NEXT:
            begin
                if (!find_b_reg)
                begin
                    cmd.op      = OP_START;
                    cmd.sel_b   = 1'b1;
                    find_b_next = 1'b1;
                    state_next  = S_F_RD;
                end
                else if (second_reg)
                    state_next = S_RD_SIZE;
                else
                    state_next = S_RD_A;
            end
            S_RD_A:
            begin
                cmd.op     = OP_READ_RA;
                state_next = S_LT_A;
            end
            S_LT_A:
            begin
                cmd.op     = OP_LATCH_A;
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                cmd.op     = OP_READ_RB;
                state_next = S_LT_B;
            end
            S_LT_B:
            begin
                cmd.op     = OP_LATCH_B;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.op     = OP_DECIDE;
                state_next = status.do_merge ? S_MERGE_L : S_RD_SIZE;
            end
            S_MERGE_L:
            begin
                cmd.op     = OP_MERGE_LOSER;
                state_next = S_MERGE_W;
            end
            S_MERGE_W:
            begin
                cmd.op      = OP_MERGE_WINNER;
                second_next = 1'b1;
                find_b_next = 1'b0;
                state_next  = S_RESTART;
            end
            S_RESTART:
            begin
                cmd.op     = OP_START;
                cmd.sel_b  = 1'b0;
                state_next = S_F_RD;
            end
            S_RD_SIZE:
            begin
                cmd.op     = OP_READ_RA;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_RESULT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            find_b_reg    <= 1'b0;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            find_b_reg    <= find_b_next;
            second_reg    <= second_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

endmodule

>>> rtl/size_limited_disjoint_set_union.sv
// per item: each find walks the parent chain to the root, then compresses the path;
//   a merge writes the loser and winner roots and then repeats both finds
// node indexes at or above NODES are first reduced by repeated subtraction of NODES
// throughput: one item at a time, set by the single read port of the node store
// reset: a clearing pass over all NODES entries initializes the node store; no input
//   transfer is taken until it ends, configuration writes are taken throughout
// ----------------------------------------------------------------------------
// size_limited_disjoint_set_union
// union-find engine with rank merging, path compression and size-limited unions
// ----------------------------------------------------------------------------
`include "size_limited_disjoint_set_union_defines.svh"

module size_limited_disjoint_set_union #(
    parameter int NODES = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sldsu_pkg::in_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output sldsu_pkg::out_t out_data,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_addr,
    input  logic [10:0]     cfg_data
);
    import sldsu_pkg::*;

    // command and status between sequencer and datapath
    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: walks each find, compresses, decides, merges, re-finds
    sldsu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: parent, rank and size store plus set count and config
    sldsu_dp #(
        .NODES (NODES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .in_item  (in_data),
        .out_item (out_data)
    );

    // a transfer in starts work, so the port closes the next cycle
    `SLDSU_ASSERT_NEXT(a_ready_drops, in_valid && in_ready, !in_ready, "ready held after transfer")
    // a merge only joins two different sets
    `SLDSU_ASSERT_SAME(a_merge_distinct, out_valid && out_data.merged, !out_data.same_set, "merged same set")
    // at least one set always remains
    `SLDSU_ASSERT_SAME(a_count_nonzero, out_valid, out_data.set_count != 11'd0, "set count zero")

endmodule
